// ===== sv/rspe_pkg.sv =====
// Package for the Reed-Solomon parity encoder: field arithmetic over GF(256),
// generator coefficients and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rspe_pkg;

  localparam int EccLen = 22;
  localparam int ByteW = 8;
  localparam int CntW = $clog2(EccLen);
  localparam int QDepth = 2;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);
  localparam logic [ByteW-1:0] GfReduce = 8'h1D;
  localparam logic [ByteW-1:0] GfTopBit = 8'h80;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [EccLen-1:0][ByteW-1:0] parity_vec_t;

  typedef struct packed {
    logic        valid;
    parity_vec_t data;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic byte_t gf_mul(input byte_t a_in, input byte_t b);
    byte_t acc;
    byte_t a;
    acc = '0;
    a = a_in;
    for (int k = 0; k < ByteW; k++) begin
      if (b[k]) begin
        acc = acc ^ a;
      end
      if ((a & GfTopBit) != '0) begin
        a = (a << 1) ^ GfReduce;
      end else begin
        a = a << 1;
      end
    end
    return acc;
  endfunction

  function automatic parity_vec_t gen_coefs();
    parity_vec_t g;
    byte_t alpha;
    g = '0;
    g[EccLen-1] = byte_t'(1);
    alpha = byte_t'(1);
    for (int r = 0; r < EccLen; r++) begin
      for (int j = 0; j < EccLen; j++) begin
        g[j] = gf_mul(g[j], alpha);
        if (j + 1 < EccLen) begin
          g[j] = g[j] ^ g[j+1];
        end
      end
      alpha = gf_mul(alpha, byte_t'(2));
    end
    return g;
  endfunction

  localparam parity_vec_t GenCoef = gen_coefs();

endpackage
`default_nettype wire

// ===== sv/rspe_msg_if.sv =====
// Message byte channel: valid/ready handshake with data byte and last flag.
// Depends on rspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rspe_msg_if
  import rspe_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t msg_byte;
  logic  msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink (input valid, input msg_byte, input msg_last, output ready);
endinterface
`default_nettype wire

// ===== sv/rspe_par_if.sv =====
// Parity byte channel: valid/ready handshake with parity byte and last flag.
// Depends on rspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rspe_par_if
  import rspe_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t parity_byte;
  logic  parity_last;

  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface
`default_nettype wire

// ===== sv/rspe_front.sv =====
// Front end: takes message bytes and runs the parity shift register.
// Pushes the finished parity of a block into the queue. Depends on rspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rspe_front
  import rspe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire byte_t   msg_byte_i,
  input  wire logic    msg_last_i,
  input  wire q_stat_t q_stat_i,
  output q_push_t      q_push_o
);

  parity_vec_t parity_q, parity_d, parity_next;
  byte_t       fb;
  logic        fire;

  assign in_ready_o = !q_stat_i.full;
  assign fire = in_valid_i && in_ready_o;
  assign fb = msg_byte_i ^ parity_q[0];

  always_comb begin
    for (int j = 0; j < EccLen; j++) begin
      if (j + 1 < EccLen) begin
        parity_next[j] = parity_q[j+1] ^ gf_mul(GenCoef[j], fb);
      end else begin
        parity_next[j] = gf_mul(GenCoef[j], fb);
      end
    end
  end

  always_comb begin
    parity_d = parity_q;
    if (fire) begin
      parity_d = msg_last_i ? '0 : parity_next;
    end
  end

  assign q_push_o.valid = fire && msg_last_i;
  assign q_push_o.data = parity_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= '0;
    end else begin
      parity_q <= parity_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rspe_queue.sv =====
// Short queue of finished parity blocks between the front and back ends.
// Depends on rspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rspe_queue
  import rspe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_push_t push_i,
  input  wire logic    pop_i,
  output parity_vec_t  head_o,
  output q_stat_t      stat_o
);

  parity_vec_t             mem_q [QDepth];
  logic [QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]        cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign stat_o.full = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i.valid && !stat_o.full;
  assign do_pop = pop_i && !stat_o.empty;
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rspe_back.sv =====
// Back end: loads a parity block from the queue and sends its bytes out,
// highest degree first. Depends on rspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rspe_back
  import rspe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire q_stat_t     q_stat_i,
  input  wire parity_vec_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output byte_t            parity_byte_o,
  output logic             parity_last_o
);

  parity_vec_t     shreg_q, shreg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            fire, done;

  assign out_valid_o = busy_q;
  assign parity_byte_o = shreg_q[0];
  assign parity_last_o = (cnt_q == CntW'(EccLen - 1));
  assign fire = busy_q && out_ready_i;
  assign done = fire && parity_last_o;
  assign q_pop_o = !q_stat_i.empty && (!busy_q || done);

  always_comb begin
    shreg_d = shreg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (q_pop_o) begin
      shreg_d = q_head_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (fire) begin
      shreg_d = shreg_q >> ByteW;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/reed_solomon_parity_encoder.sv =====
// Top level of the GF(256) Reed-Solomon parity encoder (field polynomial 0x11D).
// Depends on rspe_pkg, rspe_msg_if, rspe_par_if, rspe_front, rspe_queue, rspe_back.
//
// Message bytes are taken one per cycle; the parity shift register in the front
// end updates in the cycle of each transfer. When the byte marked last is taken,
// the finished parity block goes into a two-block queue and the back end sends
// its EccLen bytes, one per cycle while the output is ready, highest degree
// first. The output port sets the sustained rate when blocks are shorter than
// EccLen bytes. The input stalls only while the queue holds two unsent blocks.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module reed_solomon_parity_encoder
  import rspe_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  rspe_msg_if.sink msg_i,
  rspe_par_if.source par_o
);

  q_push_t     q_push;
  q_stat_t     q_stat;
  parity_vec_t q_head;
  logic        q_pop;

  rspe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (msg_i.valid),
    .in_ready_o (msg_i.ready),
    .msg_byte_i (msg_i.msg_byte),
    .msg_last_i (msg_i.msg_last),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push)
  );

  rspe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  rspe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (par_o.valid),
    .out_ready_i   (par_o.ready),
    .parity_byte_o (par_o.parity_byte),
    .parity_last_o (par_o.parity_last)
  );

  // A finished block is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> !q_stat.full)
    else $error("parity block pushed into full queue");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // After the final parity byte with nothing queued, the output goes idle.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (par_o.valid && par_o.ready && par_o.parity_last && q_stat.empty)
    |=> !par_o.valid)
    else $error("output valid without a queued block");

  // The input is stalled exactly while the queue is full.
  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.ready == !q_stat.full)
    else $error("input ready disagrees with queue state");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for reed_solomon_parity_encoder: drives message blocks, predicts
// the parity bytes with its own GF(256) encoder and compares every parity transfer.
// Depends on rspe_pkg, rspe_msg_if, rspe_par_if and the encoder RTL.
`timescale 1ns / 1ps
module testbench;
  import rspe_pkg::*;

  localparam byte_t FieldPoly = 8'h1D;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct {
    byte_t parity;
    logic  is_last;
  } parity_word_t;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   error_count;
  int   cycle_count;
  int   parity_seen;

  byte_t rs_gen[EccLen];
  byte_t parity_state[EccLen];
  parity_word_t parity_expect_q[$];

  rspe_msg_if msg_if ();
  rspe_par_if par_if ();

  reed_solomon_parity_encoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .msg_i (msg_if),
    .par_o (par_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic byte_t gf_times(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x = a;
    for (int k = 0; k < ByteW; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      if (x[ByteW-1]) begin
        x = byte_t'(x << 1) ^ FieldPoly;
      end else begin
        x = byte_t'(x << 1);
      end
    end
    return acc;
  endfunction

  // Expands the product of (x - 2^i) for i = 0 .. EccLen-1, leading 1 dropped.
  function automatic void build_rs_generator();
    byte_t alpha;
    alpha = byte_t'(1);
    for (int j = 0; j < EccLen; j++) begin
      rs_gen[j] = '0;
      parity_state[j] = '0;
    end
    rs_gen[EccLen-1] = byte_t'(1);
    for (int r = 0; r < EccLen; r++) begin
      for (int j = 0; j < EccLen; j++) begin
        rs_gen[j] = gf_times(rs_gen[j], alpha);
        if (j + 1 < EccLen) begin
          rs_gen[j] = rs_gen[j] ^ rs_gen[j+1];
        end
      end
      alpha = gf_times(alpha, byte_t'(2));
    end
  endfunction

  function automatic void absorb_msg_byte(input byte_t data, input logic last_flag);
    byte_t fb;
    fb = data ^ parity_state[0];
    for (int j = 0; j < EccLen - 1; j++) begin
      parity_state[j] = parity_state[j+1];
    end
    parity_state[EccLen-1] = '0;
    for (int j = 0; j < EccLen; j++) begin
      parity_state[j] = parity_state[j] ^ gf_times(rs_gen[j], fb);
    end
    if (last_flag) begin
      for (int j = 0; j < EccLen; j++) begin
        parity_expect_q.push_back('{parity: parity_state[j], is_last: (j == EccLen - 1)});
        parity_state[j] = '0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && msg_if.valid && msg_if.ready) begin
      absorb_msg_byte(msg_if.msg_byte, msg_if.msg_last);
    end
  end

  always @(posedge clk_i) begin
    parity_word_t want;
    if (rst_ni && par_if.valid && par_if.ready) begin
      if (parity_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected parity transfer %02h last %0b",
                                  par_if.parity_byte, par_if.parity_last));
      end else begin
        want = parity_expect_q.pop_front();
        if (par_if.parity_byte !== want.parity) begin
          report_mismatch($sformatf("parity byte %0d: got %02h, want %02h",
                                    parity_seen, par_if.parity_byte, want.parity));
        end
        if (par_if.parity_last !== want.is_last) begin
          report_mismatch($sformatf("parity byte %0d: last flag got %0b, want %0b",
                                    parity_seen, par_if.parity_last, want.is_last));
        end
      end
      parity_seen++;
    end
  end

  always @(posedge clk_i) begin
    par_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer takes place.
  task automatic send_msg(input byte_t data, input logic last_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    msg_if.valid    <= 1'b1;
    msg_if.msg_byte <= data;
    msg_if.msg_last <= last_flag;
    do begin
      @(posedge clk_i);
    end while (!msg_if.ready);
  endtask

  task automatic test_single_byte_blocks();
    send_msg(8'h00, 1'b1);
    send_msg(8'hFF, 1'b1);
    send_msg(8'h01, 1'b1);
    send_msg(8'h80, 1'b1);
  endtask

  task automatic test_field_extremes();
    for (int i = 0; i < 5; i++) begin
      send_msg(8'hFF, (i == 4));
    end
    for (int i = 0; i < 3; i++) begin
      send_msg(8'h00, (i == 2));
    end
  endtask

  task automatic test_queue_backpressure();
    int saved_pct;
    saved_pct = recv_idle_pct;
    recv_idle_pct = 90;
    for (int i = 0; i < 6; i++) begin
      send_msg(byte_t'($urandom_range(255)), 1'b1);
    end
    recv_idle_pct = saved_pct;
  endtask

  task automatic test_random_blocks(input int n_items);
    int sent;
    int block_len;
    byte_t data;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        block_len = $urandom_range(30, 1);
      end else begin
        block_len = $urandom_range(70, 31);
      end
      if (block_len > n_items - sent) begin
        block_len = n_items - sent;
      end
      for (int i = 0; i < block_len; i++) begin
        case ($urandom_range(9))
          0: data = 8'h00;
          1: data = 8'hFF;
          default: data = byte_t'($urandom_range(255));
        endcase
        send_msg(data, (i == block_len - 1));
      end
      sent += block_len;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    msg_if.valid    = 1'b0;
    msg_if.msg_byte = '0;
    msg_if.msg_last = 1'b0;
    par_if.ready    = 1'b0;
    send_idle_pct   = 35;
    recv_idle_pct   = 55;
    error_count     = 0;
    cycle_count     = 0;
    parity_seen     = 0;
    build_rs_generator();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_blocks();
    test_field_extremes();
    test_queue_backpressure();

    test_random_blocks(143);
    send_idle_pct = 55;
    recv_idle_pct = 35;
    test_random_blocks(143);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_blocks(144);
    msg_if.valid <= 1'b0;

    while (parity_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (parity_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d parity bytes never arrived", parity_expect_q.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
